FILE: design/mos_pkg.sv
`timescale 1ns / 1ps
// Package for the mask overlap similarity unit: widths, opcodes, sequencer states.
// No dependencies.
package mos_pkg;
    localparam int CNT_W = 25;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam int MAX_CAT = 16;
    localparam int TBL_AW = 8;
    localparam int RATIO_CAP = 10;
    localparam logic [15:0] DELTA_DEFAULT = 16'd655;
    localparam logic [47:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NEG_LIMIT = 48'h8000_0000_0000;

    typedef enum logic [1:0] {
        OP_PIXEL  = 2'd0,
        OP_FINISH = 2'd1,
        OP_LOAD_MIX = 2'd2,
        OP_LOAD_CON = 2'd3
    } opcode_t;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_DELTA = 3'd1;
    localparam logic [2:0] REG_SCALE = 3'd2;
    localparam logic [2:0] REG_ROWS = 3'd3;
    localparam logic [2:0] REG_COLS = 3'd4;

    localparam logic [2:0] MODE_IOU = 3'd1;
    localparam logic [2:0] MODE_INV = 3'd2;
    localparam logic [2:0] MODE_FIRST = 3'd3;
    localparam logic [2:0] MODE_SECOND = 3'd4;
    localparam logic [2:0] MODE_COMP = 3'd5;
    localparam logic [2:0] MODE_MIX = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PIX_RD, ST_PIX_ACC, ST_M5_MUL1, ST_M5_MUL2, ST_M5_HI,
        ST_DIV_START, ST_DIV_RUN, ST_POST, ST_SCALE_LO, ST_SCALE_HI, ST_SCALE_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quot;
    } div_rsp_t;
endpackage

FILE: design/mos_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module mos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/mos_div.sv
`timescale 1ns / 1ps
// Restoring divider: floor(num * 2^16 / den), saturated to 64 bits, one bit a cycle.
// Depends on mos_pkg.
module mos_div
    import mos_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [63:0] rem_reg, rem_next;
    logic [63:0] lo_reg, lo_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;
    logic        ge;

    always_comb begin
        rem_next = rem_reg;
        lo_next = lo_reg;
        q_next = q_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted = {rem_reg, lo_reg[63]};
        ge = shifted >= {1'b0, den_reg};
        if (req.start) begin
            den_next = req.den;
            rem_next = {48'd0, req.num[63:48]};
            lo_next = {req.num[47:0], 16'd0};
            q_next = '0;
            cnt_next = 7'd64;
            if ({48'd0, req.num[63:48]} >= req.den) begin
                q_next = '1;
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            lo_next = {lo_reg[62:0], 1'b0};
            if (ge) begin
                rem_next = 64'(shifted - {1'b0, den_reg});
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                rem_next = shifted[63:0];
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        lo_reg <= lo_next;
        q_reg <= q_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
endmodule

FILE: design/mask_overlap_similarity_unit.sv
`timescale 1ns / 1ps
// Mask overlap similarity unit: counts mask pixels, emits a signed Q32.16 match value on finish.
// Throughput: a table load transfers every cycle; a pixel holds s_tready low through the
// ST_PIX_RD (table read) and ST_PIX_ACC (accumulate) states. One item at a time.
// Finish: m_tvalid rises after divider setup, the divider wait, post clamps and scaling;
// mode 5 products are multiplied first, the upper clamp divides again; no divide skips the wait.
// Reset (aresetn, synchronous) clears counters and sets registers to defaults; tables keep data.
module mask_overlap_similarity_unit
    import mos_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata from bit 0: opcode[1:0], in_first, in_second, in_third, cat_first[7:0],
    // cat_second[7:0], table_row[3:0], table_col[3:0], entry_value[31:0]; pad to 64
    input  logic [63:0] s_tdata,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: match_value[47:0]
    output logic [47:0] m_tdata,
    // tuser: status
    output logic        m_tuser
);
    // configuration registers
    logic [2:0]  mode_reg;
    logic [15:0] delta_reg;
    logic [23:0] scale_reg;
    logic [4:0]  rows_reg, cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IOU;
            delta_reg <= DELTA_DEFAULT;
            scale_reg <= 24'd65536;
            rows_reg <= 5'd16;
            cols_reg <= 5'd16;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MODE:  mode_reg <= cfg_wdata[2:0];
                REG_DELTA: delta_reg <= cfg_wdata[15:0];
                REG_SCALE: scale_reg <= cfg_wdata;
                REG_ROWS:  rows_reg <= cfg_wdata[4:0];
                REG_COLS:  cols_reg <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // unpack input
    logic [1:0]  in_op;
    logic        in_f, in_s, in_t;
    logic [7:0]  in_cf, in_cs;
    logic [3:0]  in_row, in_col;
    logic [31:0] in_val;
    assign in_op = s_tdata[1:0];
    assign in_f = s_tdata[2];
    assign in_s = s_tdata[3];
    assign in_t = s_tdata[4];
    assign in_cf = s_tdata[12:5];
    assign in_cs = s_tdata[20:13];
    assign in_row = s_tdata[24:21];
    assign in_col = s_tdata[28:25];
    assign in_val = s_tdata[60:29];

    state_t state_reg, state_next;
    logic [CNT_W-1:0] fc_reg, sc_reg, tc_reg, bc_reg, ec_reg, ftc_reg;
    logic [CNT_W-1:0] fc_next, sc_next, tc_next, bc_next, ec_next, ftc_next;
    logic [63:0] msum_reg, msum_next, csum_reg, csum_next;
    logic        rerr_reg, rerr_next;
    logic        addv_reg, addv_next;       // hold: pixel adds table values
    logic [TBL_AW-1:0] raddr_reg, raddr_next;
    logic [63:0] a_reg, a_next;             // numerator / work
    logic [63:0] b_reg, b_next;             // denominator / work
    logic [63:0] mag_reg, mag_next;
    logic        neg_reg, neg_next, err_reg, err_next;
    logic [31:0] mop_a;
    logic [24:0] mop_b;
    logic [56:0] prod_reg;
    logic [47:0] out_reg, out_next;
    logic        outerr_reg, outerr_next;
    logic        ovf_reg, ovf_next;

    // table memories
    logic        mix_we, con_we;
    logic [31:0] mix_rd, con_rd;
    logic [TBL_AW-1:0] waddr;
    assign waddr = {in_row, in_col};

    mos_ram #(.WIDTH(32), .DEPTH(256)) u_mix_ram (
        .aclk(aclk), .we(mix_we), .waddr(waddr), .wdata(in_val),
        .raddr(raddr_reg), .rdata(mix_rd)
    );
    mos_ram #(.WIDTH(32), .DEPTH(256)) u_con_ram (
        .aclk(aclk), .we(con_we), .waddr(waddr), .wdata(in_val),
        .raddr(raddr_reg), .rdata(con_rd)
    );

    div_req_t div_req;
    div_rsp_t div_rsp;
    mos_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    // shared multiplier, registered output
    always_ff @(posedge aclk) begin
        prod_reg <= 57'(mop_a) * 57'(mop_b);
    end

    function automatic logic [CNT_W-1:0] sinc(input logic [CNT_W-1:0] c, input logic en);
        return (en && c != CNT_MAX) ? c + 1'b1 : c;
    endfunction

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign mix_we = s_fire && in_op == OP_LOAD_MIX;
    assign con_we = s_fire && in_op == OP_LOAD_CON;

    logic [4:0]  rows_cap, cols_cap;
    logic        okf, oks;
    logic [15:0] dlt;
    logic [63:0] cap_q;
    assign rows_cap = (rows_reg > 5'd16) ? 5'd16 : rows_reg;
    assign cols_cap = (cols_reg > 5'd16) ? 5'd16 : cols_reg;
    assign okf = in_cf >= 8'd1 && in_cf <= {3'd0, rows_cap};
    assign oks = in_cs >= 8'd1 && in_cs <= {3'd0, cols_cap};
    assign dlt = (delta_reg == 16'd0) ? DELTA_DEFAULT : delta_reg;
    assign cap_q = 64'(RATIO_CAP) << 16;

    always_comb begin
        state_next = state_reg;
        fc_next = fc_reg; sc_next = sc_reg; tc_next = tc_reg;
        bc_next = bc_reg; ec_next = ec_reg; ftc_next = ftc_reg;
        msum_next = msum_reg; csum_next = csum_reg; rerr_next = rerr_reg;
        addv_next = addv_reg; raddr_next = raddr_reg;
        a_next = a_reg; b_next = b_reg; mag_next = mag_reg;
        neg_next = neg_reg; err_next = err_reg;
        out_next = out_reg; outerr_next = outerr_reg; ovf_next = ovf_reg;
        mop_a = '0; mop_b = '0;
        div_req = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (in_op == OP_PIXEL) begin
                        fc_next = sinc(fc_reg, in_f);
                        sc_next = sinc(sc_reg, in_s);
                        tc_next = sinc(tc_reg, in_t);
                        bc_next = sinc(bc_reg, in_f && in_s);
                        ec_next = sinc(ec_reg, in_f || in_s);
                        ftc_next = sinc(ftc_reg, in_f && in_t);
                        if ((in_f && !okf) || (in_s && !oks)) rerr_next = 1'b1;
                        addv_next = in_f && in_s && okf && oks;
                        raddr_next = TBL_AW'({in_cf[3:0] - 4'd1, in_cs[3:0] - 4'd1});
                        state_next = ST_PIX_RD;
                    end else if (in_op == OP_FINISH) begin
                        neg_next = 1'b0; err_next = 1'b0; mag_next = '0;
                        state_next = ST_POST;
                        unique case (mode_reg)
                            MODE_IOU: if (ec_reg != '0) begin
                                a_next = 64'(bc_reg); b_next = 64'(ec_reg);
                                state_next = ST_DIV_START;
                            end
                            MODE_INV: begin
                                if (sc_reg > fc_reg) begin
                                    if (bc_reg == '0) mag_next = cap_q;
                                    else begin
                                        a_next = 64'(ec_reg); b_next = 64'(bc_reg);
                                        state_next = ST_DIV_START;
                                    end
                                end else if (ec_reg != '0) begin
                                    a_next = 64'(bc_reg); b_next = 64'(ec_reg);
                                    state_next = ST_DIV_START;
                                end
                            end
                            MODE_FIRST: if (fc_reg != '0) begin
                                a_next = 64'(bc_reg); b_next = 64'(fc_reg);
                                state_next = ST_DIV_START;
                            end
                            MODE_SECOND: if (sc_reg != '0) begin
                                a_next = 64'(bc_reg); b_next = 64'(sc_reg);
                                state_next = ST_DIV_START;
                            end
                            MODE_COMP: begin
                                if (bc_reg != '0 && sc_reg != '0) begin
                                    if (ftc_reg != '0) state_next = ST_M5_MUL1;
                                    else begin
                                        a_next = 64'(bc_reg); b_next = 64'(sc_reg);
                                        state_next = ST_DIV_START;
                                    end
                                end else if (ftc_reg != '0) begin
                                    a_next = 64'(tc_reg); b_next = 64'(ftc_reg);
                                    state_next = ST_DIV_START;
                                end else begin
                                    mag_next = 64'h1_0000;
                                end
                            end
                            MODE_MIX: begin
                                if (rerr_reg) err_next = 1'b1;
                                else if (csum_reg != '0 && !csum_reg[63]) begin
                                    neg_next = msum_reg[63];
                                    a_next = msum_reg[63] ? 64'(0 - msum_reg) : msum_reg;
                                    b_next = csum_reg;
                                    state_next = ST_DIV_START;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ST_PIX_RD: state_next = ST_PIX_ACC;
            ST_PIX_ACC: begin
                if (addv_reg) begin
                    msum_next = msum_reg + {{32{mix_rd[31]}}, mix_rd};
                    csum_next = csum_reg + {{32{con_rd[31]}}, con_rd};
                end
                state_next = ST_IDLE;
            end
            ST_M5_MUL1: begin
                // both * third
                mop_a = 32'(bc_reg); mop_b = tc_reg;
                state_next = ST_M5_MUL2;
            end
            ST_M5_MUL2: begin
                a_next = 64'(prod_reg[49:0]);
                mop_a = 32'(sc_reg); mop_b = ftc_reg;
                state_next = ST_M5_HI;
            end
            ST_M5_HI: begin
                b_next = 64'(prod_reg[49:0]);
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                div_req.start = 1'b1;
                div_req.num = a_reg;
                div_req.den = b_reg;
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                if (div_rsp.done) begin
                    mag_next = div_rsp.quot;
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                // mode-specific post clamps
                if (mode_reg == MODE_INV && sc_reg > fc_reg && mag_reg > cap_q)
                    mag_next = cap_q;
                if (mode_reg == MODE_COMP) begin
                    if (mag_reg < 64'(dlt)) mag_next = 64'(dlt);
                    // upper clamp floor(2^32/d): computed by divider form is costly; use
                    // compare of mag*d against 2^32 on the multiplier in next steps
                    b_next = (mag_reg < 64'(dlt)) ? 64'(dlt) : mag_reg;
                end
                state_next = ST_SCALE_LO;
            end
            ST_SCALE_LO: begin
                if (mode_reg == MODE_COMP) begin
                    // v*d > 2^32 - 1 holds for every v > floor(2^32/d), and also for v = 2^32/d, where hi = v
                    // b_reg holds v; only its low 32 bits go to the multiplier, the upper bits are tested apart
                    mop_a = b_reg[31:0]; mop_b = {9'd0, dlt};
                end
                state_next = ST_SCALE_HI;
            end
            ST_SCALE_HI: begin
                if (mode_reg == MODE_COMP) begin
                    if (b_reg[63:32] != '0 || prod_reg[56:32] != '0) begin
                        // clamp to floor(2^32/d) via divider of 2^16 by d
                        a_next = 64'h1_0000;
                        b_next = 64'(dlt);
                        div_req.start = 1'b1;
                        div_req.num = 64'h1_0000;
                        div_req.den = 64'(dlt);
                        state_next = ST_SCALE_FIN;
                    end else begin
                        mag_next = b_reg;
                        state_next = ST_OUT;
                        ovf_next = 1'b0;
                        a_next = b_reg;
                    end
                end else begin
                    a_next = mag_reg;
                    state_next = ST_OUT;
                end
                b_next = '0;
            end
            ST_SCALE_FIN: begin
                if (div_rsp.done) begin
                    a_next = div_rsp.quot;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // scale: low partial then high partial over a counter in b_reg
                if (b_reg == 64'd0) begin
                    mop_a = a_reg[31:0]; mop_b = {1'b0, scale_reg};
                    b_next = 64'd1;
                end else if (b_reg == 64'd1) begin
                    mag_next = 64'(prod_reg[56:16]);
                    mop_a = a_reg[63:32]; mop_b = {1'b0, scale_reg};
                    b_next = 64'd2;
                end else if (b_reg == 64'd2) begin
                    ovf_next = prod_reg[56:32] != '0;
                    mag_next = mag_reg + {prod_reg[47:0], 16'd0};
                    b_next = 64'd3;
                end else if (b_reg == 64'd3) begin
                    if (err_reg) out_next = '0;
                    else if (neg_reg) begin
                        out_next = (ovf_reg || mag_reg > 64'(NEG_LIMIT))
                                   ? NEG_LIMIT : 48'(0 - mag_reg);
                    end else begin
                        out_next = (ovf_reg || mag_reg > 64'(POS_LIMIT))
                                   ? POS_LIMIT : mag_reg[47:0];
                    end
                    outerr_next = err_reg;
                    fc_next = '0; sc_next = '0; tc_next = '0;
                    bc_next = '0; ec_next = '0; ftc_next = '0;
                    msum_next = '0; csum_next = '0; rerr_next = 1'b0;
                    b_next = 64'd4;
                end else if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fc_reg <= '0; sc_reg <= '0; tc_reg <= '0;
            bc_reg <= '0; ec_reg <= '0; ftc_reg <= '0;
            msum_reg <= '0; csum_reg <= '0; rerr_reg <= 1'b0;
            b_reg <= '0;
        end else begin
            state_reg <= state_next;
            fc_reg <= fc_next; sc_reg <= sc_next; tc_reg <= tc_next;
            bc_reg <= bc_next; ec_reg <= ec_next; ftc_reg <= ftc_next;
            msum_reg <= msum_next; csum_reg <= csum_next; rerr_reg <= rerr_next;
            b_reg <= b_next;
        end
        addv_reg <= addv_next; raddr_reg <= raddr_next;
        a_reg <= a_next; mag_reg <= mag_next;
        neg_reg <= neg_next; err_reg <= err_next;
        out_reg <= out_next; outerr_reg <= outerr_next; ovf_reg <= ovf_next;
    end

    assign m_tvalid = (state_reg == ST_OUT) && (b_reg == 64'd4);
    assign m_tdata = out_reg;
    assign m_tuser = outerr_reg;
endmodule
